// File: rtl/rtdc_pkg.sv
// rtdc_pkg: shared types and constants for the rtd code to celsius pipeline
// used by every module in rtl; depends on nothing
`default_nettype none

package rtdc_pkg;

  localparam int SENSOR_COUNT = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_REFERENCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READY_MASK = 2'd1;

  localparam logic [16:0] REFERENCE_RESET = 17'd4300;

  localparam int SQRT_STAGES = 30;

  // resistance window in units of 1/327680 ohm
  localparam logic [32:0] P_MIN = 33'd3276800;
  localparam logic [32:0] P_MAX = 33'd163840000;

  // discriminant scaled by 4096e14
  localparam logic [43:0] E_OFFSET = 44'd7202737721344;
  localparam logic [42:0] E_COEF   = 43'd28875;

  localparam logic [30:0] ROOT_OFFSET = 31'd640335872;
  localparam logic [41:0] HALF_DEN    = 42'd118272;
  // ceil(2^39 / 231), exact for quotients of values below 2^31
  localparam logic [62:0] RECIP_231   = 63'd2379895299;

  localparam logic signed [24:0] TEMP_MIN = -25'sd30000;
  localparam logic signed [24:0] TEMP_MAX = 25'sd150000;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_FAULT     = 3'd2,
    ST_ZERO      = 3'd3,
    ST_RANGE     = 3'd4
  } rtdc_status_t;

  typedef struct packed {
    rtdc_status_t status;
    logic [59:0]  rad;
    logic [31:0]  rem;
    logic [29:0]  root;
  } sq_t;

endpackage

`default_nettype wire

// File: rtl/rtdc_front.sv
// rtdc_front: status checks, resistance product and discriminant stages
// depends on rtdc_pkg
`default_nettype none

module rtdc_front (
  input  wire logic        clk,
  input  wire logic        ld_a,
  input  wire logic        ld_b,
  input  wire logic        in_sensor_number,
  input  wire logic [7:0]  in_fault_byte,
  input  wire logic [15:0] in_rtd_code,
  input  wire logic [16:0] reference_r,
  input  wire logic [1:0]  ready_mask_r,
  output rtdc_pkg::sq_t    cell_o
);
  import rtdc_pkg::*;

  rtdc_status_t status_a_nxt, status_a_r;
  logic [32:0]  p_full;
  logic [32:0]  p_a_r;
  logic [42:0]  prod_b;
  logic [43:0]  e_b;
  sq_t          cell_nxt, cell_r;

  assign p_full = 33'(in_rtd_code) * 33'(reference_r);

  always_comb begin
    if (32'(in_sensor_number) >= SENSOR_COUNT || !ready_mask_r[in_sensor_number]) begin
      status_a_nxt = ST_NOT_READY;
    end else if (in_fault_byte != 8'd0) begin
      status_a_nxt = ST_FAULT;
    end else if (in_rtd_code == 16'd0) begin
      status_a_nxt = ST_ZERO;
    end else if (p_full < P_MIN || p_full > P_MAX) begin
      status_a_nxt = ST_RANGE;
    end else begin
      status_a_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      status_a_r <= status_a_nxt;
      p_a_r      <= p_full;
    end
  end

  assign prod_b = E_COEF * 43'(p_a_r[27:0]);
  assign e_b    = E_OFFSET - 44'(prod_b);

  always_comb begin
    cell_nxt.status = status_a_r;
    cell_nxt.rad    = {1'b0, e_b[42:0], 16'd0};
    cell_nxt.rem    = 32'd0;
    cell_nxt.root   = 30'd0;
  end

  always_ff @(posedge clk) begin
    if (ld_b) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

// File: rtl/rtdc_sqrt_cell.sv
// rtdc_sqrt_cell: one restoring square root step, one root bit per cell
// depends on rtdc_pkg
`default_nettype none

module rtdc_sqrt_cell (
  input  wire logic     clk,
  input  wire logic     ld,
  input  rtdc_pkg::sq_t cell_i,
  output rtdc_pkg::sq_t cell_o
);
  import rtdc_pkg::*;

  logic [33:0] r2;
  logic [33:0] trial;
  sq_t         cell_nxt, cell_r;

  assign r2    = {cell_i.rem, cell_i.rad[59:58]};
  assign trial = {2'b00, cell_i.root, 2'b01};

  always_comb begin
    cell_nxt.status = cell_i.status;
    cell_nxt.rad    = {cell_i.rad[57:0], 2'b00};
    if (r2 >= trial) begin
      cell_nxt.rem  = 32'(r2 - trial);
      cell_nxt.root = {cell_i.root[28:0], 1'b1};
    end else begin
      cell_nxt.rem  = r2[31:0];
      cell_nxt.root = {cell_i.root[28:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      cell_r <= cell_nxt;
    end
  end

  assign cell_o = cell_r;

endmodule

`default_nettype wire

// File: rtl/rtdc_back.sv
// rtdc_back: root to hundredths of a degree, rounding, clamp, result register
// depends on rtdc_pkg
`default_nettype none

module rtdc_back (
  input  wire logic         clk,
  input  wire logic         ld_c,
  input  wire logic         ld_d,
  input  wire logic         ld_e,
  input  wire logic         ld_f,
  input  rtdc_pkg::sq_t     cell_i,
  output logic [2:0]        status_o,
  output logic signed [18:0] temp_o,
  output logic              clear_o
);
  import rtdc_pkg::*;

  logic signed [30:0] d_c;
  logic signed [40:0] num_c;
  logic signed [40:0] num_r;
  rtdc_status_t       status_c_r, status_d_r, status_e_r, status_f_r;
  logic [40:0]        mag_d;
  logic [41:0]        n_d;
  logic [30:0]        m_r;
  logic               neg_d_r, neg_e_r;
  logic [62:0]        prod_e;
  logic [62:0]        prod_r;
  logic signed [24:0] q_f;
  logic signed [24:0] t_f;
  logic signed [24:0] t_nxt;
  logic signed [18:0] temp_r;

  assign d_c   = signed'(ROOT_OFFSET - {1'b0, cell_i.root});
  assign num_c = 41'(d_c) * 41'sd125;

  always_ff @(posedge clk) begin
    if (ld_c) begin
      num_r      <= num_c;
      status_c_r <= cell_i.status;
    end
  end

  assign mag_d = num_r[40] ? 41'(-num_r) : num_r;
  assign n_d   = 42'(mag_d) + HALF_DEN;

  always_ff @(posedge clk) begin
    if (ld_d) begin
      m_r        <= n_d[40:10];
      neg_d_r    <= num_r[40];
      status_d_r <= status_c_r;
    end
  end

  assign prod_e = 63'(m_r) * RECIP_231;

  always_ff @(posedge clk) begin
    if (ld_e) begin
      prod_r     <= prod_e;
      neg_e_r    <= neg_d_r;
      status_e_r <= status_d_r;
    end
  end

  assign q_f = signed'({1'b0, prod_r[62:39]});
  assign t_f = neg_e_r ? -q_f : q_f;

  always_comb begin
    if (status_e_r != ST_OK) begin
      t_nxt = 25'sd0;
    end else if (t_f < TEMP_MIN) begin
      t_nxt = TEMP_MIN;
    end else if (t_f > TEMP_MAX) begin
      t_nxt = TEMP_MAX;
    end else begin
      t_nxt = t_f;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_f) begin
      temp_r     <= t_nxt[18:0];
      status_f_r <= status_e_r;
    end
  end

  assign status_o = status_f_r;
  assign temp_o   = temp_r;
  assign clear_o  = (status_f_r == ST_FAULT);

endmodule

`default_nettype wire

// File: rtl/rtd_code_to_celsius.sv
// rtd_code_to_celsius: pt100 code to temperature, top level
// depends on rtdc_pkg, rtdc_front, rtdc_sqrt_cell, rtdc_back
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | sensor_number, fault_byte, rtd_code
//   out_    | output    | out_valid/out_stall| status, temperature_centi, clear_fault_request
//   cfg_    | input     | cfg_valid/cfg_ready| index, data
//
// one transaction per cycle while the output is not stalled; 2 front stages, 30 root cells,
// 3 scaling stages and a result register
// every stage holds its data and loads when empty or when the stage after it loads
// a stalled result still lets the pipe fill its empty stages behind it
// rst_n clears valid bits and the ready mask and sets the reference to REFERENCE_RESET; cfg_ready is always high
`default_nettype none

module rtd_code_to_celsius (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_sensor_number,
  input  wire logic [7:0]                     in_fault_byte,
  input  wire logic [15:0]                    in_rtd_code,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_status,
  output logic signed [18:0]                  out_temperature_centi,
  output logic                                out_clear_fault_request,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rtdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rtdc_pkg::*;

  localparam int NST = SQRT_STAGES + 6;

  logic [16:0]  reference_r;
  logic [1:0]   ready_mask_r;
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   ld;
  sq_t          chain [0:SQRT_STAGES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reference_r  <= REFERENCE_RESET;
      ready_mask_r <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_REFERENCE) begin
        reference_r <= cfg_data[16:0];
      end else if (cfg_index == REG_READY_MASK) begin
        ready_mask_r <= cfg_data[1:0];
      end
    end
  end

  assign ld[NST] = !out_valid || !out_stall;

  genvar g;
  generate
    for (g = 0; g < NST; g++) begin : g_ld
      assign ld[g] = !vld_r[g] || ld[g+1];
      if (g == 0) begin : g_first
        assign vld_nxt[g] = ld[g] ? in_valid : vld_r[g];
      end else begin : g_rest
        assign vld_nxt[g] = ld[g] ? vld_r[g-1] : vld_r[g];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !ld[0];
  assign out_valid = vld_r[NST-1];

  rtdc_front u_front (
    .clk              (clk),
    .ld_a             (ld[0]),
    .ld_b             (ld[1]),
    .in_sensor_number (in_sensor_number),
    .in_fault_byte    (in_fault_byte),
    .in_rtd_code      (in_rtd_code),
    .reference_r      (reference_r),
    .ready_mask_r     (ready_mask_r),
    .cell_o           (chain[0])
  );

  generate
    for (g = 0; g < SQRT_STAGES; g++) begin : g_cell
      rtdc_sqrt_cell u_cell (
        .clk    (clk),
        .ld     (ld[g+2]),
        .cell_i (chain[g]),
        .cell_o (chain[g+1])
      );
    end
  endgenerate

  rtdc_back u_back (
    .clk      (clk),
    .ld_c     (ld[NST-4]),
    .ld_d     (ld[NST-3]),
    .ld_e     (ld[NST-2]),
    .ld_f     (ld[NST-1]),
    .cell_i   (chain[SQRT_STAGES]),
    .status_o (out_status),
    .temp_o   (out_temperature_centi),
    .clear_o  (out_clear_fault_request)
  );

  a_zero_temp_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_temperature_centi == 19'sd0)
    else $error("nonzero temperature with error status");

  a_clear_only_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_clear_fault_request == (out_status == ST_FAULT))
    else $error("clear request does not match fault status");

  a_temp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK |->
      out_temperature_centi >= -19'sd30000 && out_temperature_centi <= 19'sd150000)
    else $error("temperature outside range");

  a_stall_blocks_full: assert property (@(posedge clk) disable iff (!rst_n)
    &vld_r && out_stall |-> in_stall)
    else $error("input taken while pipe full and stalled");

endmodule

`default_nettype wire

// File: verif/rtdc_checker.sv
// rtdc_checker: watches the in_, out_ and cfg_ channels of rtd_code_to_celsius,
// predicts every result from its own register copies and compares field by field
// depends on rtdc_pkg
`timescale 1ns / 1ps

module rtdc_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic        in_sensor_number,
  input  wire logic [7:0]  in_fault_byte,
  input  wire logic [15:0] in_rtd_code,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [2:0]  out_status,
  input  wire logic signed [18:0] out_temperature_centi,
  input  wire logic        out_clear_fault_request,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [rtdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rtdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output int               errors,
  output int               pending
);
  import rtdc_pkg::*;

  typedef struct packed {
    rtdc_status_t       status;
    logic signed [18:0] temp;
    logic               clr;
  } reading_t;

  logic [16:0] ref_tenth;
  logic [1:0]  ready_mask;
  reading_t    expected_readings[$];
  int          ok_seen;

  assign pending = expected_readings.size();

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic reading_t convert_reading(input logic sn, input logic [7:0] fb,
                                               input logic [15:0] code);
    reading_t r;
    longint p, e, t;
    r = '{status: ST_OK, temp: '0, clr: 1'b0};
    p = longint'(code) * longint'(ref_tenth);
    if (!ready_mask[sn]) begin
      r.status = ST_NOT_READY;
    end else if (fb != 0) begin
      r.status = ST_FAULT;
      r.clr = 1'b1;
    end else if (code == 0) begin
      r.status = ST_ZERO;
    end else if (p < 64'd3276800 || p > 64'd163840000) begin
      r.status = ST_RANGE;
    end else begin
      e = 64'sd7202737721344 - 64'sd28875 * p;
      if (e < 0) t = round_div(64'sd15625 * (p - 64'sd32768000), 64'sd20010496);
      else t = round_div(64'sd625 * (64'sd640335872 - longint'(int_sqrt(e << 16))),
                         64'sd1182720);
      if (t < -30000) t = -30000;
      if (t > 150000) t = 150000;
      r.temp = t[18:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      ref_tenth <= REFERENCE_RESET;
      ready_mask <= '0;
      expected_readings.delete();
      errors <= 0;
      ok_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REFERENCE) ref_tenth <= cfg_data[16:0];
        else if (cfg_index == REG_READY_MASK) ready_mask <= cfg_data[1:0];
      end
      if (in_valid && !in_stall)
        expected_readings.push_back(convert_reading(in_sensor_number, in_fault_byte,
                                                    in_rtd_code));
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected transaction, status", out_status, -1);
        end else begin
          want = expected_readings.pop_front();
          if (out_status != want.status) report_mismatch("status", out_status, want.status);
          if (out_temperature_centi != want.temp)
            report_mismatch("temperature_centi", out_temperature_centi, want.temp);
          if (out_clear_fault_request != want.clr)
            report_mismatch("clear_fault_request", out_clear_fault_request, want.clr);
          if (want.status == ST_OK) ok_seen <= ok_seen + 1;
        end
      end
    end
  end
endmodule

// File: verif/rtd_code_to_celsius_test.sv
// rtd_code_to_celsius_test: stimulus, idle profiles, watchdog and verdict
// depends on rtdc_pkg, rtd_code_to_celsius and rtdc_checker
`timescale 1ns / 1ps

module rtd_code_to_celsius_test;
  import rtdc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 40;

  logic clk, rst_n;
  logic in_valid, in_stall, in_sensor_number;
  logic [7:0] in_fault_byte;
  logic [15:0] in_rtd_code;
  logic out_valid, out_stall, out_clear_fault_request;
  logic [2:0] out_status;
  logic signed [18:0] out_temperature_centi;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int errors, pending;
  int send_idle_pct, recv_stall_pct, hold_cycles, idle_count, items_sent;
  logic [16:0] cur_ref;

  rtd_code_to_celsius dut (.*);

  rtdc_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("** rtd_code_to_celsius: FAILED **");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    if (idx == REG_REFERENCE) cur_ref = val[16:0];
  endtask

  // called at a falling edge; returns at a falling edge with in_valid still high
  task automatic send_reading(input logic sn, input logic [7:0] fb, input logic [15:0] code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_sensor_number <= sn;
    in_fault_byte <= fb;
    in_rtd_code <= code;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_random;
    int lo, hi, kind;
    logic [15:0] code;
    kind = $urandom_range(99);
    lo = (cur_ref == 0) ? 65536 : (3276800 + cur_ref - 1) / cur_ref;
    hi = (cur_ref == 0) ? 0 : 163840000 / cur_ref;
    if (hi > 65535) hi = 65535;
    if (kind < 75 && lo <= hi) code = $urandom_range(hi, lo);
    else code = $urandom;
    send_reading((kind < 85) ? 1'b0 : $urandom, (kind >= 75 && kind < 88) ? $urandom : 8'd0,
                 code);
    if (kind >= 94) send_reading($urandom, $urandom, $urandom);
  endtask

  initial begin
    logic [16:0] refs[5];
    refs = '{17'd4300, 17'd100, 17'd100000, 17'd10000, 17'd0};
    rst_n = 0;
    in_valid = 0;
    in_sensor_number = 0;
    in_fault_byte = 0;
    in_rtd_code = 0;
    cfg_valid = 0;
    cfg_index = REG_REFERENCE;
    cfg_data = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    items_sent = 0;
    cur_ref = REFERENCE_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // not ready after reset, then the edge cases under several settings
    send_reading(0, 0, 16'd8192);
    send_reading(1, 0, 16'd8192);
    write_reg(REG_READY_MASK, 32'd1);
    send_reading(1, 0, 16'd8192);
    send_reading(0, 0, 16'd8192);
    send_reading(0, 8'hff, 16'hffff);
    send_reading(0, 8'h01, 16'd0);
    send_reading(0, 0, 16'd0);
    send_reading(0, 0, 16'd1);
    send_reading(0, 0, 16'hffff);
    send_reading(0, 0, 16'd762);
    send_reading(0, 0, 16'd761);
    write_reg(REG_READY_MASK, 32'hfffffff2);
    send_reading(0, 0, 16'd8192);
    send_reading(1, 8'h80, 16'd8192);
    send_reading(1, 0, 16'd38102);
    send_reading(1, 0, 16'd38103);
    write_reg(REG_REFERENCE, 32'd100);
    write_reg(REG_READY_MASK, 32'd3);
    send_reading(0, 0, 16'd32768);
    send_reading(1, 0, 16'd32767);
    send_reading(0, 0, 16'hffff);
    write_reg(REG_REFERENCE, 32'd10000);
    send_reading(0, 0, 16'd16384);
    send_reading(1, 0, 16'd16385);
    write_reg(REG_REFERENCE, 32'd0);
    send_reading(0, 0, 16'd12345);
    write_reg(REG_SPARE, 32'hffffffff);
    send_reading(0, 0, 16'd12345);

    for (int ph = 0; ph < 5; ph++) begin
      in_valid <= 0;
      send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 55 : 0;
      recv_stall_pct = (ph < 2) ? 55 : (ph < 4) ? 16 : 0;
      write_reg(REG_REFERENCE, (ph == 3) ? {$urandom, 17'd0} | $urandom_range(100000, 100)
                                         : {$urandom, 17'd0} | refs[ph]);
      write_reg(REG_READY_MASK, (ph == 4) ? $urandom : 32'd3);
      if (ph == 1) hold_cycles = 300;
      for (int i = 0; i < 240; i++) begin
        if (ph == 2 && i == 120) begin
          in_valid <= 0;
          while (pending != 0) @(negedge clk);
        end
        send_random();
      end
    end
    in_valid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d readings (%0d converted ok) over five register settings",
             items_sent, checker_i.ok_seen);
    $display("with sender and receiver idle profiles, a long hold-off and a full drain");
    if (errors == 0) begin
      $display("** rtd_code_to_celsius: PASSED **");
    end else begin
      $display("** rtd_code_to_celsius: FAILED **");
    end
    $finish;
  end
endmodule

// File: rtd_code_to_celsius.f
rtl/rtdc_pkg.sv
rtl/rtdc_front.sv
rtl/rtdc_sqrt_cell.sv
rtl/rtdc_back.sv
rtl/rtd_code_to_celsius.sv
verif/rtdc_checker.sv
verif/rtd_code_to_celsius_test.sv
